// ===== rtl/ppg_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the plasma pixel generator
// holds the signed sine table and colorwheel sextant codes; no dependencies

package ppg_pkg;

    // hue circle length after tripling
    localparam int unsigned HUE_RANGE = 1536;

    // colorwheel sextant codes taken from hue[10:8]
    typedef enum logic [2:0] {
        SEXT_RED_YELLOW    = 3'd0,
        SEXT_YELLOW_GREEN  = 3'd1,
        SEXT_GREEN_CYAN    = 3'd2,
        SEXT_CYAN_BLUE     = 3'd3,
        SEXT_BLUE_MAGENTA  = 3'd4,
        SEXT_MAGENTA_RED   = 3'd5
    } sextant_t;

    typedef logic signed [7:0] wave_t;

    // one period of a signed sine, 256 entries
    localparam wave_t WAVE_ROM [256] = '{
        8'sd0,    8'sd2,    8'sd5,    8'sd8,    8'sd11,   8'sd15,   8'sd18,   8'sd21,
        8'sd24,   8'sd27,   8'sd30,   8'sd33,   8'sd36,   8'sd39,   8'sd42,   8'sd45,
        8'sd48,   8'sd51,   8'sd54,   8'sd56,   8'sd59,   8'sd62,   8'sd65,   8'sd67,
        8'sd70,   8'sd72,   8'sd75,   8'sd77,   8'sd80,   8'sd82,   8'sd85,   8'sd87,
        8'sd89,   8'sd91,   8'sd93,   8'sd96,   8'sd98,   8'sd100,  8'sd101,  8'sd103,
        8'sd105,  8'sd107,  8'sd108,  8'sd110,  8'sd111,  8'sd113,  8'sd114,  8'sd116,
        8'sd117,  8'sd118,  8'sd119,  8'sd120,  8'sd121,  8'sd122,  8'sd123,  8'sd123,
        8'sd124,  8'sd125,  8'sd125,  8'sd126,  8'sd126,  8'sd126,  8'sd126,  8'sd126,
        8'sd127,  8'sd126,  8'sd126,  8'sd126,  8'sd126,  8'sd126,  8'sd125,  8'sd125,
        8'sd124,  8'sd123,  8'sd123,  8'sd122,  8'sd121,  8'sd120,  8'sd119,  8'sd118,
        8'sd117,  8'sd116,  8'sd114,  8'sd113,  8'sd111,  8'sd110,  8'sd108,  8'sd107,
        8'sd105,  8'sd103,  8'sd101,  8'sd100,  8'sd98,   8'sd96,   8'sd93,   8'sd91,
        8'sd89,   8'sd87,   8'sd85,   8'sd82,   8'sd80,   8'sd77,   8'sd75,   8'sd72,
        8'sd70,   8'sd67,   8'sd65,   8'sd62,   8'sd59,   8'sd56,   8'sd54,   8'sd51,
        8'sd48,   8'sd45,   8'sd42,   8'sd39,   8'sd36,   8'sd33,   8'sd30,   8'sd27,
        8'sd24,   8'sd21,   8'sd18,   8'sd15,   8'sd11,   8'sd8,    8'sd5,    8'sd2,
        8'sd0,    -8'sd3,   -8'sd6,   -8'sd9,   -8'sd12,  -8'sd16,  -8'sd19,  -8'sd22,
        -8'sd25,  -8'sd28,  -8'sd31,  -8'sd34,  -8'sd37,  -8'sd40,  -8'sd43,  -8'sd46,
        -8'sd49,  -8'sd52,  -8'sd55,  -8'sd57,  -8'sd60,  -8'sd63,  -8'sd66,  -8'sd68,
        -8'sd71,  -8'sd73,  -8'sd76,  -8'sd78,  -8'sd81,  -8'sd83,  -8'sd86,  -8'sd88,
        -8'sd90,  -8'sd92,  -8'sd94,  -8'sd97,  -8'sd99,  -8'sd101, -8'sd102, -8'sd104,
        -8'sd106, -8'sd108, -8'sd109, -8'sd111, -8'sd112, -8'sd114, -8'sd115, -8'sd117,
        -8'sd118, -8'sd119, -8'sd120, -8'sd121, -8'sd122, -8'sd123, -8'sd124, -8'sd124,
        -8'sd125, -8'sd126, -8'sd126, -8'sd127, -8'sd127, -8'sd127, -8'sd127, -8'sd127,
        8'sh80,   -8'sd127, -8'sd127, -8'sd127, -8'sd127, -8'sd127, -8'sd126, -8'sd126,
        -8'sd125, -8'sd124, -8'sd124, -8'sd123, -8'sd122, -8'sd121, -8'sd120, -8'sd119,
        -8'sd118, -8'sd117, -8'sd115, -8'sd114, -8'sd112, -8'sd111, -8'sd109, -8'sd108,
        -8'sd106, -8'sd104, -8'sd102, -8'sd101, -8'sd99,  -8'sd97,  -8'sd94,  -8'sd92,
        -8'sd90,  -8'sd88,  -8'sd86,  -8'sd83,  -8'sd81,  -8'sd78,  -8'sd76,  -8'sd73,
        -8'sd71,  -8'sd68,  -8'sd66,  -8'sd63,  -8'sd60,  -8'sd57,  -8'sd55,  -8'sd52,
        -8'sd49,  -8'sd46,  -8'sd43,  -8'sd40,  -8'sd37,  -8'sd34,  -8'sd31,  -8'sd28,
        -8'sd25,  -8'sd22,  -8'sd19,  -8'sd16,  -8'sd12,  -8'sd9,   -8'sd6,   -8'sd3
    };

endpackage

// ===== rtl/plasma_pixel_generator.sv =====
`timescale 1ns / 1ps
// plasma pixel generator top level: six-stage pixel color pipeline
// depends on ppg_pkg for the sine table and sextant codes

// Takes one pixel position with four wave centers and a hue shift per word
// and returns that pixel's RGB color. The pipeline has six register stages:
// center offsets, squares, table lookup, wave sum, hue wrap, colorwheel and
// saturation. A word enters every clock while in_stall is low and its
// color leaves from the last register; each stage holds its word under
// output stall and accepts a new one as soon as it empties, so bubbles are
// squeezed out. The saturation register (reset 255) is read by the last
// stage and is meant to be written only while no word is in flight.

module plasma_pixel_generator #(
    parameter int PANEL_SIZE = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [7:0]                    cfg_wr_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [$clog2(PANEL_SIZE)-1:0] pixel_x,
    input  logic [$clog2(PANEL_SIZE)-1:0] pixel_y,
    input  logic signed [7:0]             center_one_x,
    input  logic signed [7:0]             center_one_y,
    input  logic signed [7:0]             center_two_x,
    input  logic signed [7:0]             center_two_y,
    input  logic signed [7:0]             center_three_x,
    input  logic signed [7:0]             center_three_y,
    input  logic signed [7:0]             center_four_x,
    input  logic signed [7:0]             center_four_y,
    input  logic [8:0]                    hue_offset,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    red,
    output logic [7:0]                    green,
    output logic [7:0]                    blue
);

    import ppg_pkg::*;

    localparam int PW     = $clog2(PANEL_SIZE);
    localparam int DW     = ((PW > 8) ? PW : 8) + 1;   // signed offset width
    localparam int SQW    = 2 * DW;                   // square width
    localparam int D2W    = SQW + 1;                  // sum of squares width
    localparam int STAGES = 6;
    localparam int SUMW   = 11;                       // hue + four waves
    localparam int TW     = 14;                       // tripled sum width

    localparam logic [TW-1:0]  HUE_RANGE_T  = TW'(HUE_RANGE);
    localparam logic [TW-1:0]  HUE_RANGE2_T = TW'(2 * HUE_RANGE);

    // saturation register
    logic [7:0] saturation_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saturation_reg <= 8'hFF;
        end
        else if (cfg_wr_en)
        begin
            saturation_reg <= cfg_wr_data;
        end
    end

    // stage valid bits and per-stage advance chain
    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   advance;

    always_comb
    begin
        advance[STAGES] = !out_stall;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            advance[k] = !valid_reg[k] || advance[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (advance[k])
                begin
                    valid_reg[k] <= (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign in_stall  = !advance[0];
    assign out_valid = valid_reg[STAGES-1];

    // gather center coordinates into lanes
    logic signed [7:0] cx [4];
    logic signed [7:0] cy [4];

    always_comb
    begin
        cx[0] = center_one_x;
        cy[0] = center_one_y;
        cx[1] = center_two_x;
        cy[1] = center_two_y;
        cx[2] = center_three_x;
        cy[2] = center_three_y;
        cx[3] = center_four_x;
        cy[3] = center_four_y;
    end

    // stage 1: center offsets
    logic signed [DW-1:0] dx_next [4];
    logic signed [DW-1:0] dy_next [4];
    logic signed [DW-1:0] dx_reg  [4];
    logic signed [DW-1:0] dy_reg  [4];
    logic [8:0]           hue1_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            dx_next[i] = DW'(cx[i]) - $signed(DW'(pixel_x));
            dy_next[i] = DW'(cy[i]) - $signed(DW'(pixel_y));
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance[0])
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            hue1_reg <= hue_offset;
        end
    end

    // stage 2: squares
    logic [SQW-1:0] sqx_next [4];
    logic [SQW-1:0] sqy_next [4];
    logic [SQW-1:0] sqx_reg  [4];
    logic [SQW-1:0] sqy_reg  [4];
    logic [8:0]     hue2_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sqx_next[i] = SQW'($signed(dx_reg[i]) * $signed(dx_reg[i]));
            sqy_next[i] = SQW'($signed(dy_reg[i]) * $signed(dy_reg[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance[1])
        begin
            sqx_reg  <= sqx_next;
            sqy_reg  <= sqy_next;
            hue2_reg <= hue1_reg;
        end
    end

    // stage 3: squared distance, table index and sine lookup
    logic [D2W-1:0] d2       [4];
    logic [7:0]     rom_idx  [4];
    wave_t          wave_next [4];
    wave_t          wave_reg  [4];
    logic [8:0]     hue3_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            d2[i] = {1'b0, sqx_reg[i]} + {1'b0, sqy_reg[i]};
            // first two centers use a quarter of the squared distance, the rest an eighth
            if (i < 2)
            begin
                rom_idx[i] = d2[i][9:2];
            end
            else
            begin
                rom_idx[i] = d2[i][10:3];
            end
            wave_next[i] = WAVE_ROM[rom_idx[i]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance[2])
        begin
            wave_reg <= wave_next;
            hue3_reg <= hue2_reg;
        end
    end

    // stage 4: wave sum plus hue shift
    logic signed [SUMW-1:0] sum_next;
    logic signed [SUMW-1:0] sum_reg;

    always_comb
    begin
        sum_next = $signed({2'b00, hue3_reg})
                 + SUMW'(wave_reg[0]) + SUMW'(wave_reg[1])
                 + SUMW'(wave_reg[2]) + SUMW'(wave_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (advance[3])
        begin
            sum_reg <= sum_next;
        end
    end

    // stage 5: triple and wrap into the hue circle
    logic [TW-1:0] tripled;
    logic [10:0]   hue_next;
    logic [10:0]   hue_reg;

    always_comb
    begin
        // tripled sum plus one turn lies in [0, 3 turns)
        tripled = TW'($signed({sum_reg, 1'b0}) + TW'(sum_reg)) + HUE_RANGE_T;
        if (tripled >= HUE_RANGE2_T)
        begin
            hue_next = 11'(tripled - HUE_RANGE2_T);
        end
        else if (tripled >= HUE_RANGE_T)
        begin
            hue_next = 11'(tripled - HUE_RANGE_T);
        end
        else
        begin
            hue_next = tripled[10:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance[4])
        begin
            hue_reg <= hue_next;
        end
    end

    // stage 6: colorwheel and pull toward white
    logic [7:0]  mix;
    logic [7:0]  wheel_r;
    logic [7:0]  wheel_g;
    logic [7:0]  wheel_b;
    logic [8:0]  sat_plus;
    logic [16:0] prod_r;
    logic [16:0] prod_g;
    logic [16:0] prod_b;
    logic [7:0]  red_next;
    logic [7:0]  green_next;
    logic [7:0]  blue_next;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;

    always_comb
    begin
        mix = hue_reg[7:0];
        unique case (sextant_t'(hue_reg[10:8]))
            SEXT_RED_YELLOW:
            begin
                wheel_r = 8'hFF;
                wheel_g = mix;
                wheel_b = 8'h00;
            end
            SEXT_YELLOW_GREEN:
            begin
                wheel_r = ~mix;
                wheel_g = 8'hFF;
                wheel_b = 8'h00;
            end
            SEXT_GREEN_CYAN:
            begin
                wheel_r = 8'h00;
                wheel_g = 8'hFF;
                wheel_b = mix;
            end
            SEXT_CYAN_BLUE:
            begin
                wheel_r = 8'h00;
                wheel_g = ~mix;
                wheel_b = 8'hFF;
            end
            SEXT_BLUE_MAGENTA:
            begin
                wheel_r = mix;
                wheel_g = 8'h00;
                wheel_b = 8'hFF;
            end
            default:
            begin
                // magenta back to red
                wheel_r = 8'hFF;
                wheel_g = 8'h00;
                wheel_b = ~mix;
            end
        endcase

        sat_plus   = {1'b0, saturation_reg} + 9'd1;
        prod_r     = {1'b0, ~wheel_r} * sat_plus;
        prod_g     = {1'b0, ~wheel_g} * sat_plus;
        prod_b     = {1'b0, ~wheel_b} * sat_plus;
        red_next   = ~prod_r[15:8];
        green_next = ~prod_g[15:8];
        blue_next  = ~prod_b[15:8];
    end

    always_ff @(posedge clk)
    begin
        if (advance[5])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule
